// File: rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
// No dependencies; imported by every module in rtl/.
package rc4_pkg;

   localparam int BYTE_W            = 8;
   localparam int PERM_DEPTH        = 256;
   localparam int PERM_ADDR_W       = 8;
   localparam int KEY_DEPTH_DEFAULT = 256;

   // req_tuser codes
   localparam logic MODE_KEY  = 1'b0;
   localparam logic MODE_DATA = 1'b1;

   localparam logic [PERM_ADDR_W-1:0] PERM_LAST = 8'hFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,      // identity fill of the permutation
      ST_KSA_RD,    // schedule: read S[n] and key byte
      ST_KSA_J,     // schedule: new j, read S[j]
      ST_KSA_WI,    // schedule: S[n] <= S[j]
      ST_KSA_WJ,    // schedule: S[j] <= old S[n]
      ST_GEN_J,     // generator: new j, read S[j]
      ST_GEN_T,     // generator: S[i] <= S[j], read S[S[i]+S[j]]
      ST_GEN_OUT    // generator: S[j] <= old S[i], emit byte
   } state_type;

   typedef struct packed {
      logic                   wr_en;
      logic [PERM_ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0]      wr_data;
      logic [PERM_ADDR_W-1:0] rd_addr;
   } perm_port_type;

endpackage

// File: rtl/rc4_perm_ram.sv
// 256 x 8 permutation memory: one write port, one read port, registered read.
// Depends on rc4_pkg.
module rc4_perm_ram (
   input  logic                  clock,
   input  rc4_pkg::perm_port_type port,
   output logic [7:0]            rd_data
);
   import rc4_pkg::*;

   logic [BYTE_W-1:0] mem [PERM_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      rd_data_ff <= mem[port.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rc4_key_ram.sv
// Key byte store: one write port, one read port, registered read.
// Depends on rc4_pkg.
module rc4_key_ram #(
   parameter int DEPTH  = rc4_pkg::KEY_DEPTH_DEFAULT,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);
   import rc4_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rc4_ctrl.sv
// Sequencer for key load, key schedule and keystream generation, plus the
// result register. Drives both memories. Depends on rc4_pkg.
module rc4_ctrl #(
   parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEFAULT,
   parameter int KEY_CNT_W = 9,
   parameter int KEY_AW    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output rc4_pkg::perm_port_type perm_port,
   input  logic [7:0]             perm_rd_data,
   output logic                   key_wr_en,
   output logic [KEY_AW-1:0]      key_wr_addr,
   output logic [7:0]             key_wr_data,
   output logic [KEY_AW-1:0]      key_rd_addr,
   input  logic [7:0]             key_rd_data
);
   import rc4_pkg::*;

   state_type state_ff, state_in;

   logic [KEY_CNT_W-1:0]   key_count_ff, key_count_in;
   logic [KEY_AW-1:0]      kp_ff, kp_in;
   logic [PERM_ADDR_W-1:0] n_ff, n_in;
   logic [PERM_ADDR_W-1:0] i_ff, i_in;
   logic [PERM_ADDR_W-1:0] j_ff, j_in;
   logic                   keyed_ff, keyed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [BYTE_W-1:0]      si_ff, si_in;
   logic [BYTE_W-1:0]      sj_ff, sj_in;
   logic [PERM_ADDR_W-1:0] t_ff, t_in;
   logic [BYTE_W-1:0]      byte_ff, byte_in;

   logic              accept;
   logic              key_room;
   logic              out_free;
   logic              kp_wrap;
   logic [BYTE_W-1:0] ks_byte;

   assign accept   = req_tvalid && req_tready;
   assign key_room = key_count_ff < KEY_CNT_W'(KEY_DEPTH);
   assign out_free = !rsp_valid_ff || rsp_tready;
   // key index runs modulo the key length; an empty key counts as length 1
   assign kp_wrap  = (KEY_CNT_W'(kp_ff) + KEY_CNT_W'(1)) >= key_count_ff;

   // S[t] after the swap: forward the two entries written this step
   always_comb begin
      priority if (t_ff == i_ff) begin
         ks_byte = sj_ff;
      end else if (t_ff == j_ff) begin
         ks_byte = si_ff;
      end else begin
         ks_byte = perm_rd_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == MODE_KEY) begin
                  if (req_tlast) state_in = ST_FILL;
               end else if (keyed_ff) begin
                  state_in = ST_GEN_J;
               end
            end
         end
         ST_FILL:    if (n_ff == PERM_LAST) state_in = ST_KSA_RD;
         ST_KSA_RD:  state_in = ST_KSA_J;
         ST_KSA_J:   state_in = ST_KSA_WI;
         ST_KSA_WI:  state_in = ST_KSA_WJ;
         ST_KSA_WJ:  state_in = (n_ff == PERM_LAST) ? ST_IDLE : ST_KSA_RD;
         ST_GEN_J:   state_in = ST_GEN_T;
         ST_GEN_T:   state_in = ST_GEN_OUT;
         ST_GEN_OUT: if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // memory ports and handshake
   always_comb begin
      req_tready        = (state_ff == ST_IDLE);
      perm_port.wr_en   = 1'b0;
      perm_port.wr_addr = n_ff;
      perm_port.wr_data = si_ff;
      perm_port.rd_addr = n_ff;
      key_rd_addr       = kp_ff;
      key_wr_en         = accept && (req_tuser == MODE_KEY) && key_room;
      key_wr_addr       = key_count_ff[KEY_AW-1:0];
      key_wr_data       = req_tdata;
      unique case (state_ff)
         ST_IDLE: perm_port.rd_addr = i_ff + 8'd1;
         ST_FILL: begin
            perm_port.wr_en   = 1'b1;
            perm_port.wr_data = n_ff;
         end
         ST_KSA_RD: perm_port.rd_addr = n_ff;
         ST_KSA_J:  perm_port.rd_addr = j_ff + perm_rd_data + key_rd_data;
         ST_KSA_WI: begin
            perm_port.wr_en   = 1'b1;
            perm_port.wr_data = perm_rd_data;
         end
         ST_KSA_WJ: begin
            perm_port.wr_en   = 1'b1;
            perm_port.wr_addr = j_ff;
         end
         ST_GEN_J: perm_port.rd_addr = j_ff + perm_rd_data;
         ST_GEN_T: begin
            perm_port.wr_en   = 1'b1;
            perm_port.wr_addr = i_ff;
            perm_port.wr_data = perm_rd_data;
            perm_port.rd_addr = si_ff + perm_rd_data;
         end
         ST_GEN_OUT: begin
            // rewriting S[j] while stalled is harmless
            perm_port.wr_en   = 1'b1;
            perm_port.wr_addr = j_ff;
            perm_port.rd_addr = t_ff;
         end
         default: ;
      endcase
   end

   // register next values
   always_comb begin
      key_count_in = key_count_ff;
      kp_in        = kp_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      keyed_in     = keyed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      byte_in      = byte_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == MODE_KEY) begin
                  if (key_room) key_count_in = key_count_ff + KEY_CNT_W'(1);
                  if (req_tlast) begin
                     n_in  = '0;
                     j_in  = '0;
                     kp_in = '0;
                  end
               end else if (keyed_ff) begin
                  i_in    = i_ff + 8'd1;
                  byte_in = req_tdata;
               end
            end
         end
         ST_FILL: n_in = n_ff + 8'd1;
         ST_KSA_J: begin
            si_in = perm_rd_data;
            j_in  = j_ff + perm_rd_data + key_rd_data;
         end
         ST_KSA_WJ: begin
            n_in  = n_ff + 8'd1;
            kp_in = kp_wrap ? '0 : kp_ff + KEY_AW'(1);
            if (n_ff == PERM_LAST) begin
               i_in         = '0;
               j_in         = '0;
               keyed_in     = 1'b1;
               key_count_in = '0;
            end
         end
         ST_GEN_J: begin
            si_in = perm_rd_data;
            j_in  = j_ff + perm_rd_data;
         end
         ST_GEN_T: begin
            sj_in = perm_rd_data;
            t_in  = si_ff + perm_rd_data;
         end
         ST_GEN_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = byte_ff ^ ks_byte;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= '0;
         kp_ff        <= '0;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         kp_ff        <= kp_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      byte_ff     <= byte_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_key_count_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KEY_CNT_W'(KEY_DEPTH))
      else $error("key count beyond key store depth");

   a_sched_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KSA_WJ && n_ff == PERM_LAST) |=>
         (keyed_ff && i_ff == '0 && j_ff == '0 && key_count_ff == '0
          && state_ff == ST_IDLE))
      else $error("key schedule did not leave generator reset and keyed");

   a_data_starts_gen: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == MODE_DATA && keyed_ff) |=> state_ff == ST_GEN_J)
      else $error("keyed data transaction did not start the generator");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_GEN_OUT)
      else $error("result loaded outside the output step");

endmodule

// File: rtl/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher: sequencer, permutation memory and
// key store. Depends on rc4_pkg, rc4_ctrl, rc4_perm_ram, rc4_key_ram.
//
//   channel  direction  tdata              tuser        tlast
//   req      in         [7:0] data_byte    [0] mode     last key byte
//   rsp      out        [7:0] out_byte     -            -
//
// Steps: a data transaction runs through accept, read S[j], write S[i]
// and read S[S[i]+S[j]], write S[j] and load the result register; the
// permutation memory, with one write and one read port, sets these steps.
// A key byte is stored as it is accepted. The key byte marked last is
// followed by an identity fill of all 256 entries and a key schedule (4
// memory steps per entry), during which no transaction is accepted.
// Reset (synchronous, active high) clears the key count, indices and the
// keyed flag; memories are not cleared. The result register holds a byte
// until taken; a data transaction waits in its last step while it is full.
module rc4_stream_cipher #(
   parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEFAULT   // 1 .. 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // last key byte, starts the key schedule
   input  logic       req_tuser,    // [0] mode: 0 key byte, 1 data byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // [7:0] out_byte
);
   import rc4_pkg::*;

   localparam int KEY_CNT_W = $clog2(KEY_DEPTH + 1);
   localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   perm_port_type     perm_port;
   logic [BYTE_W-1:0] perm_rd_data;
   logic              key_wr_en;
   logic [KEY_AW-1:0] key_wr_addr;
   logic [BYTE_W-1:0] key_wr_data;
   logic [KEY_AW-1:0] key_rd_addr;
   logic [BYTE_W-1:0] key_rd_data;

   rc4_ctrl #(
      .KEY_DEPTH (KEY_DEPTH),
      .KEY_CNT_W (KEY_CNT_W),
      .KEY_AW    (KEY_AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .perm_port    (perm_port),
      .perm_rd_data (perm_rd_data),
      .key_wr_en    (key_wr_en),
      .key_wr_addr  (key_wr_addr),
      .key_wr_data  (key_wr_data),
      .key_rd_addr  (key_rd_addr),
      .key_rd_data  (key_rd_data)
   );

   // permutation table S
   rc4_perm_ram u_perm_ram (
      .clock   (clock),
      .port    (perm_port),
      .rd_data (perm_rd_data)
   );

   // key bytes of the key being loaded
   rc4_key_ram #(
      .DEPTH  (KEY_DEPTH),
      .ADDR_W (KEY_AW)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

endmodule

// File: tb/tb.sv
// Self-checking testbench for rc4_stream_cipher: a keystream scoreboard class
// plus stream drivers. Depends on rtl/rc4_pkg.sv and rtl/rc4_stream_cipher.sv.
// Runs key loads and data bursts under random sender/receiver idling.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rc4_pkg::*;

   localparam int KEY_DEPTH   = KEY_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 300;

   // Predicts the RC4 keystream and checks each output byte against it.
   class rc4_scoreboard;
      logic [BYTE_W-1:0] sbox [PERM_DEPTH];
      logic [BYTE_W-1:0] key_bytes [PERM_DEPTH];
      int unsigned       key_len;
      logic [BYTE_W-1:0] gen_i;
      logic [BYTE_W-1:0] gen_j;
      bit                have_key;
      logic [BYTE_W-1:0] cipher_q [$];
      int unsigned       errors;

      function new();
         key_len  = 0;
         gen_i    = '0;
         gen_j    = '0;
         have_key = 1'b0;
         errors   = 0;
      endfunction

      function void schedule_key();
         int unsigned       len;
         logic [BYTE_W-1:0] j;
         logic [BYTE_W-1:0] t;
         len = (key_len == 0) ? 1 : key_len;
         j   = '0;
         for (int n = 0; n < PERM_DEPTH; n++) sbox[n] = n[BYTE_W-1:0];
         for (int n = 0; n < PERM_DEPTH; n++) begin
            j       = j + sbox[n] + key_bytes[n % len];
            t       = sbox[n];
            sbox[n] = sbox[j];
            sbox[j] = t;
         end
         gen_i    = '0;
         gen_j    = '0;
         have_key = 1'b1;
         key_len  = 0;
      endfunction

      function logic [BYTE_W-1:0] keystream_byte();
         logic [BYTE_W-1:0] t;
         gen_i       = gen_i + 8'd1;
         gen_j       = gen_j + sbox[gen_i];
         t           = sbox[gen_i];
         sbox[gen_i] = sbox[gen_j];
         sbox[gen_j] = t;
         return sbox[BYTE_W'(sbox[gen_i] + sbox[gen_j])];
      endfunction

      // One accepted request transaction.
      function void note_request(logic mode, logic [BYTE_W-1:0] value, logic last);
         if (mode == MODE_KEY) begin
            if (key_len < KEY_DEPTH) begin
               key_bytes[key_len] = value;
               key_len++;
            end
            if (last) schedule_key();
         end else if (have_key) begin
            cipher_q.push_back(value ^ keystream_byte());
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic [BYTE_W-1:0] got);
         logic [BYTE_W-1:0] want;
         if (cipher_q.size() == 0) begin
            report_mismatch($sformatf("unexpected out_byte %02h", got));
         end else begin
            want = cipher_q.pop_front();
            if (got !== want)
               report_mismatch($sformatf("out_byte %02h, want %02h", got, want));
         end
      endtask

      function int pending();
         return cipher_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // last key byte
   logic       req_tuser = 1'b0;    // [0] mode
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte

   rc4_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int items_sent    = 0;
   int cycle_count   = 0;

   rc4_stream_cipher #(.KEY_DEPTH(KEY_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: random back-pressure, plus a long hold-off on request so the
   // result register fills and the block stalls its input side.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Handshakes are sampled mid-cycle, where every signal is settled for
   // the coming rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      end
   end

   // Offers one transaction; returns at the edge that accepted it.
   task offer_byte(logic mode, logic [7:0] value, logic last);
      bit ready_seen;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      req_tlast  <= last;
      ready_seen = 1'b0;
      while (!ready_seen) begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Loads a key of len bytes, the final one marked last; data bytes may be
   // mixed in, which still use the current keystream.
   task load_key(int len, bit mix_data);
      for (int k = 0; k < len; k++) begin
         if (mix_data && $urandom_range(99) < 20)
            offer_byte(MODE_DATA, 8'($urandom), 1'($urandom));
         offer_byte(MODE_KEY, 8'($urandom), k == len - 1);
      end
   endtask

   task data_burst(int len);
      for (int k = 0; k < len; k++) offer_byte(MODE_DATA, 8'($urandom), 1'($urandom));
   endtask

   task random_traffic(int count);
      int stop_at;
      int pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 68)      data_burst($urandom_range(1, 40));
         else if (pick < 80) load_key($urandom_range(1, 16), 1'($urandom_range(1)));
         else if (pick < 88) load_key($urandom_range(17, 64), 1'($urandom_range(1)));
         else if (pick < 90) load_key($urandom_range(250, 270), 1'b0);
         else begin
            // partial key, completed by a later load
            for (int k = $urandom_range(1, 6); k > 0; k--)
               offer_byte(MODE_KEY, 8'($urandom), 1'b0);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender idles 38%, receiver 78%.
      send_idle_pct = 38;
      recv_idle_pct = 78;

      // Data before any key: no output expected.
      offer_byte(MODE_DATA, 8'h00, 1'b0);
      offer_byte(MODE_DATA, 8'hFF, 1'b1);
      // One-byte all-zero key.
      offer_byte(MODE_KEY, 8'h00, 1'b1);
      offer_byte(MODE_DATA, 8'h00, 1'b0);
      offer_byte(MODE_DATA, 8'hFF, 1'b0);
      offer_byte(MODE_DATA, 8'hA5, 1'b1);   // last is ignored on data
      // Rekey while keyed: data in between still uses the old stream.
      offer_byte(MODE_KEY, 8'hFF, 1'b0);
      offer_byte(MODE_KEY, 8'h00, 1'b0);
      offer_byte(MODE_DATA, 8'h5A, 1'b0);
      offer_byte(MODE_KEY, 8'h80, 1'b1);
      offer_byte(MODE_DATA, 8'hFF, 1'b0);
      offer_byte(MODE_DATA, 8'h00, 1'b0);
      // One-byte all-ones key.
      offer_byte(MODE_KEY, 8'hFF, 1'b1);
      data_burst(3);

      random_traffic(300);

      // Swapped idling; a key of exactly full depth, then one too long.
      send_idle_pct = 78;
      recv_idle_pct = 38;
      load_key(KEY_DEPTH, 1'b0);
      data_burst(8);
      random_traffic(120);
      load_key(KEY_DEPTH + 4, 1'b1);
      data_burst(8);
      random_traffic(120);

      // No idling; long receiver hold-off while data keeps coming.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = hold_requests + 1;
      data_burst(40);
      random_traffic(300);
      data_burst(4);
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
